@@ rtl/core/ncs_pkg.sv @@
// Package: operation codes, bus cycle kinds, command bytes and result types.
package ncs_pkg;

  localparam int unsigned LenW = 14;
  localparam int unsigned RowW = 24;
  localparam int unsigned StepW = 3;

  localparam logic [2:0] OP_READ_PAGE = 3'd0;
  localparam logic [2:0] OP_PROGRAM   = 3'd1;
  localparam logic [2:0] OP_ERASE     = 3'd2;
  localparam logic [2:0] OP_STATUS    = 3'd3;
  localparam logic [2:0] OP_READ_ID   = 3'd4;
  localparam logic [2:0] OP_DATA_WR   = 3'd5;
  localparam logic [2:0] OP_DATA_RD   = 3'd6;

  localparam logic [7:0] CMD_READ_SETUP  = 8'h00;
  localparam logic [7:0] CMD_READ_CONF   = 8'h30;
  localparam logic [7:0] CMD_PROG_SETUP  = 8'h80;
  localparam logic [7:0] CMD_PROG_CONF   = 8'h10;
  localparam logic [7:0] CMD_ERASE_SETUP = 8'h60;
  localparam logic [7:0] CMD_ERASE_CONF  = 8'hD0;
  localparam logic [7:0] CMD_STATUS      = 8'h70;
  localparam logic [7:0] CMD_READ_ID     = 8'h90;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;

  localparam logic [LenW-1:0] PAGE_LEN_RESET = LenW'(2112);

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_ADDR = 2'd1,
    KIND_DATA = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] bus_byte;
    logic       last;
    logic       error;
  } res_t;

  typedef struct packed {
    res_t res;
    logic none;
  } dec_t;

endpackage

@@ rtl/core/ncs_if.sv @@
// Interfaces: request, bus cycle and configuration channels.
interface ncs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [23:0] page_row;
  logic [7:0]  data_byte;
  modport source (output valid, output operation, output page_row, output data_byte,
                  input ready);
  modport sink (input valid, input operation, input page_row, input data_byte,
                output ready);
endinterface

interface ncs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cycle_kind;
  logic [7:0] bus_byte;
  logic       last;
  logic       error;
  modport source (output valid, output cycle_kind, output bus_byte, output last,
                  output error, input ready);
  modport sink (input valid, input cycle_kind, input bus_byte, input last,
                input error, output ready);
endinterface

interface ncs_cfg_if;
  logic        valid;
  logic        ready;
  logic [13:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ncs_step_dec.sv @@
// Step decoder: bus cycle for one step of the held request.
module ncs_step_dec (
  input  logic [2:0]               op,
  input  logic [ncs_pkg::RowW-1:0] row,
  input  logic [7:0]               wr_byte,
  input  logic [ncs_pkg::StepW-1:0] step,
  input  logic                     left_zero,
  input  logic                     left_one,
  output ncs_pkg::dec_t            dec
);
  import ncs_pkg::*;

  always_comb begin
    dec.none         = 1'b0;
    dec.res.kind     = KIND_ADDR;
    dec.res.bus_byte = BYTE_ZERO;
    dec.res.last     = 1'b0;
    dec.res.error    = 1'b0;
    unique case (op) inside
      OP_READ_PAGE, OP_PROGRAM: begin
        unique case (step)
          3'd0: begin
            dec.res.kind     = KIND_CMD;
            dec.res.bus_byte = (op == OP_PROGRAM) ? CMD_PROG_SETUP : CMD_READ_SETUP;
          end
          3'd3: dec.res.bus_byte = row[7:0];
          3'd4: dec.res.bus_byte = row[15:8];
          3'd5: begin
            dec.res.bus_byte = row[23:16];
            dec.res.last     = (op == OP_PROGRAM);
          end
          3'd6: begin
            dec.res.kind     = KIND_CMD;
            dec.res.bus_byte = CMD_READ_CONF;
            dec.res.last     = 1'b1;
          end
          default: dec.res.bus_byte = BYTE_ZERO;
        endcase
      end
      OP_ERASE: begin
        unique case (step)
          3'd0: begin
            dec.res.kind     = KIND_CMD;
            dec.res.bus_byte = CMD_ERASE_SETUP;
          end
          3'd1: dec.res.bus_byte = row[7:0];
          3'd2: dec.res.bus_byte = row[15:8];
          3'd3: dec.res.bus_byte = row[23:16];
          default: begin
            dec.res.kind     = KIND_CMD;
            dec.res.bus_byte = CMD_ERASE_CONF;
            dec.res.last     = 1'b1;
          end
        endcase
      end
      OP_STATUS: begin
        if (step == 3'd0) begin
          dec.res.kind     = KIND_CMD;
          dec.res.bus_byte = CMD_STATUS;
        end else begin
          dec.res.kind = KIND_READ;
          dec.res.last = 1'b1;
        end
      end
      OP_READ_ID: begin
        unique case (step)
          3'd0: begin
            dec.res.kind     = KIND_CMD;
            dec.res.bus_byte = CMD_READ_ID;
          end
          3'd1: dec.res.kind = KIND_ADDR;
          default: begin
            dec.res.kind = KIND_READ;
            dec.res.last = (step == 3'd6);
          end
        endcase
      end
      OP_DATA_WR: begin
        if (left_zero) begin
          dec.res.kind  = KIND_CMD;
          dec.res.last  = 1'b1;
          dec.res.error = 1'b1;
        end else if (step == 3'd0) begin
          dec.res.kind     = KIND_DATA;
          dec.res.bus_byte = wr_byte;
          dec.res.last     = !left_one;
        end else begin
          dec.res.kind     = KIND_CMD;
          dec.res.bus_byte = CMD_PROG_CONF;
          dec.res.last     = 1'b1;
        end
      end
      OP_DATA_RD: begin
        dec.res.kind = KIND_READ;
        dec.res.last = 1'b1;
      end
      default: dec.none = 1'b1;
    endcase
  end

endmodule

@@ rtl/core/ncs_out_reg.sv @@
// Output register: holds one bus cycle word until the sink takes it.
module ncs_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ncs_pkg::res_t d,
  output logic          free,
  ncs_out_if.source     out_s
);
  import ncs_pkg::*;

  logic valid_r;
  res_t data_r;

  assign free = !valid_r || out_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= d;
    end
  end

  assign out_s.valid      = valid_r;
  assign out_s.cycle_kind = data_r.kind;
  assign out_s.bus_byte   = data_r.bus_byte;
  assign out_s.last       = data_r.last;
  assign out_s.error      = data_r.error;

endmodule

@@ rtl/core/nand_command_cycle_sequencer.sv @@
// Top level: NAND command cycle sequencer.
// Each request word becomes one to seven bus cycle words, issued one per clock while the
// sink takes them, from a held request register through the output register; a data
// write or data read causes one bus cycle, a write that completes a page two, and a
// page read up to seven. The next request is taken in the cycle its last bus cycle is
// issued. The unused operation code is dropped with no output. The page length register
// is written through cfg_s; the user is to write it only while the block is idle, which
// the block itself does not enforce. A program setup loads the byte count from it, and
// a length of zero counts as one.
module nand_command_cycle_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  ncs_in_if.sink     in_s,
  ncs_out_if.source  out_s,
  ncs_cfg_if.sink    cfg_s
);
  import ncs_pkg::*;

  logic             hold_v_r;
  logic [2:0]       op_r;
  logic [RowW-1:0]  row_r;
  logic [7:0]       byte_r;
  logic [StepW-1:0] step_r;
  logic [LenW-1:0]  left_r;
  logic [LenW-1:0]  plen_r;
  logic [LenW-1:0]  left_nxt;

  dec_t dec;
  logic out_free;
  logic emit;
  logic retire;
  logic accept;

  ncs_step_dec u_dec (
    .op        (op_r),
    .row       (row_r),
    .wr_byte   (byte_r),
    .step      (step_r),
    .left_zero (left_r == '0),
    .left_one  (left_r == LenW'(1)),
    .dec       (dec)
  );

  ncs_out_reg u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (emit),
    .d     (dec.res),
    .free  (out_free),
    .out_s (out_s)
  );

  assign emit        = hold_v_r && !dec.none && out_free;
  assign retire      = hold_v_r && (dec.none || (out_free && dec.res.last));
  assign in_s.ready  = !hold_v_r || retire;
  assign accept      = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;

  always_comb begin
    left_nxt = left_r;
    if (op_r == OP_PROGRAM) begin
      left_nxt = (plen_r == '0) ? LenW'(1) : plen_r;
    end else if (op_r == OP_DATA_WR && left_r != '0) begin
      left_nxt = left_r - LenW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      step_r   <= '0;
      left_r   <= '0;
      plen_r   <= PAGE_LEN_RESET;
    end else begin
      if (cfg_s.valid) begin
        plen_r <= cfg_s.data;
      end
      if (retire) begin
        step_r <= '0;
        left_r <= left_nxt;
      end else if (emit) begin
        step_r <= step_r + StepW'(1);
      end
      if (accept) begin
        hold_v_r <= 1'b1;
      end else if (retire) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_s.operation;
      row_r  <= in_s.page_row;
      byte_r <= in_s.data_byte;
    end
  end

`ifndef SYNTHESIS
  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid && out_s.error |-> out_s.last && out_s.cycle_kind == KIND_CMD)
    else $error("error word not a final command cycle");

  a_count_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(retire) |-> left_r == $past(left_r))
    else $error("program byte count changed mid request");

  a_single_step_ops: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && op_r == OP_DATA_RD |-> step_r == '0)
    else $error("data read advanced past its only cycle");
`endif

endmodule

@@ dv/nand_command_cycle_sequencer_tb.sv @@
// Testbench: random and directed requests against a bus-cycle predictor, checked word by word.
module nand_command_cycle_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned IDLE_PCT = 33;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    logic [2:0]      op;
    logic [RowW-1:0] row;
    logic [7:0]      wbyte;
  } request_t;

  logic clk;
  logic rst_n;

  ncs_in_if  in_if();
  ncs_out_if out_if();
  ncs_cfg_if cfg_if();

  nand_command_cycle_sequencer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if),
    .cfg_s (cfg_if)
  );

  request_t        requests_pending[$];
  res_t            bus_cycles_due[$];
  logic [LenW-1:0] page_len;
  logic [LenW-1:0] prog_left;
  bit              in_offer;
  bit              no_idle;
  bit              hold_req;
  int              hold_left;
  int              cfg_writes;
  int              errors;
  int              stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic res_t bus_cycle(kind_t k, logic [7:0] b);
    res_t r;
    r.kind = k;
    r.bus_byte = b;
    r.last = 1'b0;
    r.error = 1'b0;
    return r;
  endfunction

  function automatic void predict_bus_cycles(logic [2:0] op, logic [RowW-1:0] row,
                                             logic [7:0] wbyte);
    res_t burst[$];
    res_t stray;
    case (op)
      OP_READ_PAGE: begin
        burst.push_back(bus_cycle(KIND_CMD, CMD_READ_SETUP));
        burst.push_back(bus_cycle(KIND_ADDR, BYTE_ZERO));
        burst.push_back(bus_cycle(KIND_ADDR, BYTE_ZERO));
        burst.push_back(bus_cycle(KIND_ADDR, row[7:0]));
        burst.push_back(bus_cycle(KIND_ADDR, row[15:8]));
        burst.push_back(bus_cycle(KIND_ADDR, row[23:16]));
        burst.push_back(bus_cycle(KIND_CMD, CMD_READ_CONF));
      end
      OP_PROGRAM: begin
        burst.push_back(bus_cycle(KIND_CMD, CMD_PROG_SETUP));
        burst.push_back(bus_cycle(KIND_ADDR, BYTE_ZERO));
        burst.push_back(bus_cycle(KIND_ADDR, BYTE_ZERO));
        burst.push_back(bus_cycle(KIND_ADDR, row[7:0]));
        burst.push_back(bus_cycle(KIND_ADDR, row[15:8]));
        burst.push_back(bus_cycle(KIND_ADDR, row[23:16]));
        prog_left = (page_len == '0) ? LenW'(1) : page_len;
      end
      OP_ERASE: begin
        burst.push_back(bus_cycle(KIND_CMD, CMD_ERASE_SETUP));
        burst.push_back(bus_cycle(KIND_ADDR, row[7:0]));
        burst.push_back(bus_cycle(KIND_ADDR, row[15:8]));
        burst.push_back(bus_cycle(KIND_ADDR, row[23:16]));
        burst.push_back(bus_cycle(KIND_CMD, CMD_ERASE_CONF));
      end
      OP_STATUS: begin
        burst.push_back(bus_cycle(KIND_CMD, CMD_STATUS));
        burst.push_back(bus_cycle(KIND_READ, BYTE_ZERO));
      end
      OP_READ_ID: begin
        burst.push_back(bus_cycle(KIND_CMD, CMD_READ_ID));
        burst.push_back(bus_cycle(KIND_ADDR, BYTE_ZERO));
        repeat (5) burst.push_back(bus_cycle(KIND_READ, BYTE_ZERO));
      end
      OP_DATA_WR: begin
        if (prog_left == '0) begin
          stray = bus_cycle(KIND_CMD, BYTE_ZERO);
          stray.error = 1'b1;
          burst.push_back(stray);
        end else begin
          burst.push_back(bus_cycle(KIND_DATA, wbyte));
          prog_left = prog_left - LenW'(1);
          if (prog_left == '0) burst.push_back(bus_cycle(KIND_CMD, CMD_PROG_CONF));
        end
      end
      OP_DATA_RD: burst.push_back(bus_cycle(KIND_READ, BYTE_ZERO));
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) bus_cycles_due.push_back(burst[i]);
  endfunction

  // accept words, predict, check, watch for stalls
  always @(posedge clk) begin
    res_t got;
    res_t want;
    bit   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        page_len = cfg_if.data;
        cfg_writes++;
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        predict_bus_cycles(in_if.operation, in_if.page_row, in_if.data_byte);
        in_offer = 1'b0;
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got.kind = kind_t'(out_if.cycle_kind);
        got.bus_byte = out_if.bus_byte;
        got.last = out_if.last;
        got.error = out_if.error;
        if (bus_cycles_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual kind=%0d byte=%h last=%b err=%b",
                   $time, got.kind, got.bus_byte, got.last, got.error);
          errors++;
        end else begin
          want = bus_cycles_due.pop_front();
          if (got.kind !== want.kind || got.bus_byte !== want.bus_byte ||
              got.last !== want.last || got.error !== want.error) begin
            $display("%0t: mismatch: expected kind=%0d byte=%h last=%b err=%b, actual kind=%0d byte=%h last=%b err=%b",
                     $time, want.kind, want.bus_byte, want.last, want.error,
                     got.kind, got.bus_byte, got.last, got.error);
            errors++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("nand_command_cycle_sequencer_tb: FAIL");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && !in_offer) begin
      if (requests_pending.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = requests_pending.pop_front();
        in_offer = 1'b1;
        in_if.valid <= 1'b1;
        in_if.operation <= nxt.op;
        in_if.page_row <= nxt.row;
        in_if.data_byte <= nxt.wbyte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // bus cycle receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  function automatic void queue_request(logic [2:0] op, logic [RowW-1:0] row,
                                        logic [7:0] wbyte);
    request_t r;
    r.op = op;
    r.row = row;
    r.wbyte = wbyte;
    requests_pending.push_back(r);
  endfunction

  task automatic settle();
    while (requests_pending.size() > 0 || in_offer || bus_cycles_due.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_page_len(input logic [LenW-1:0] v);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly page programs with random content, some broken or interleaved, some noise
  task automatic queue_traffic(input int n, input int eff_len);
    int made;
    int writes;
    logic [2:0] op;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 70) begin
        queue_request(OP_PROGRAM, RowW'($urandom), 8'($urandom));
        made++;
        writes = (eff_len > 8) ? $urandom_range(1, 8) : eff_len;
        if ($urandom_range(0, 9) == 0) writes = $urandom_range(0, writes);
        repeat (writes) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_request(3'($urandom_range(0, 6)), RowW'($urandom), 8'($urandom));
            made++;
          end
          queue_request(OP_DATA_WR, RowW'($urandom), 8'($urandom));
          made++;
        end
      end else begin
        op = 3'($urandom_range(0, 7));
        queue_request(op, RowW'($urandom), 8'($urandom));
        if (op != OP_UNUSED) made++;
      end
    end
  endtask

  initial begin
    int len;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.page_row = '0;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    page_len = PAGE_LEN_RESET;
    prog_left = '0;
    in_offer = 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    cfg_writes = 0;
    errors = 0;
    stall_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_request(OP_DATA_WR, 24'h000000, 8'hFF);
    queue_request(OP_UNUSED, 24'hFFFFFF, 8'hFF);
    queue_request(OP_READ_PAGE, 24'h000000, 8'h00);
    queue_request(OP_READ_PAGE, 24'hFFFFFF, 8'hFF);
    queue_request(OP_ERASE, 24'hA5A5A5, 8'h00);
    queue_request(OP_ERASE, 24'h5A5A5A, 8'h00);
    queue_request(OP_STATUS, 24'h000000, 8'h00);
    queue_request(OP_READ_ID, 24'h000000, 8'h00);
    queue_request(OP_DATA_RD, 24'h000000, 8'h00);
    queue_request(OP_PROGRAM, 24'hFFFFFF, 8'h00);
    queue_request(OP_DATA_WR, 24'h000000, 8'h00);
    queue_request(OP_DATA_WR, 24'h000000, 8'hFF);
    queue_request(OP_READ_PAGE, 24'h123456, 8'h00);
    queue_request(OP_ERASE, 24'h000000, 8'h00);
    queue_request(OP_PROGRAM, 24'h000000, 8'hFF);
    queue_request(OP_DATA_WR, 24'h000000, 8'h5A);
    queue_request(OP_UNUSED, 24'h000000, 8'h00);
    queue_request(OP_DATA_RD, 24'h000000, 8'h00);
    settle();

    write_page_len(LenW'(0));
    queue_request(OP_PROGRAM, 24'h00FF00, 8'h00);
    queue_request(OP_DATA_WR, 24'h000000, 8'hA5);
    queue_request(OP_DATA_WR, 24'h000000, 8'h3C);
    settle();

    write_page_len(LenW'(16383));
    queue_request(OP_PROGRAM, 24'hFF00FF, 8'h00);
    queue_request(OP_DATA_WR, 24'h000000, 8'h81);
    queue_request(OP_DATA_WR, 24'h000000, 8'h7E);
    queue_request(OP_STATUS, 24'h000000, 8'h00);
    settle();

    write_page_len(LenW'(1));
    queue_traffic(15, 1);
    settle();

    write_page_len(LenW'(8192));
    queue_traffic(8, 8192);
    settle();

    no_idle = 1'b1;
    write_page_len(LenW'(3));
    queue_traffic(20, 3);
    settle();
    no_idle = 1'b0;

    len = $urandom_range(2, 7);
    write_page_len(LenW'(len));
    hold_req = 1'b1;
    queue_traffic(30, len);
    settle();

    if (errors == 0 && bus_cycles_due.size() == 0) begin
      $display("nand_command_cycle_sequencer_tb: PASS");
    end else begin
      $display("nand_command_cycle_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
